### rtl/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 16;
  localparam int TAG_BITS = 16;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int OCC_BITS = 5;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_PEEK   = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]          command;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [KEY_BITS-1:0] min_key;
    logic [TAG_BITS-1:0] min_tag;
    logic [OCC_BITS-1:0] occupancy;
  } out_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

### rtl/spq_cell.sv
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic              valid,
  input  logic              prev_greater,
  input  spq_pkg::entry_t   prev_entry,
  input  spq_pkg::entry_t   next_entry,
  output logic              greater,
  output spq_pkg::entry_t   entry
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // slot is past the insert point: empty or holds a strictly larger key
  assign greater = !valid || (entry_r.key > ctl.new_entry.key);
  assign entry   = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && greater) begin
      entry_nxt = prev_greater ? prev_entry : ctl.new_entry;
    end else if (ctl.pop) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### rtl/sorted_priority_queue.sv
// Result: strobed in the cycle after the command beat is accepted.
// Throughput: one command per cycle; busy is never raised. Each cell compares
// and shifts in the same cycle, so the cell chain sets the rate.
// Reset: synchronous, active low; clears the entry count and the strobe.
// Results are never stalled by the receiver.
module sorted_priority_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  spq_pkg::in_t in_item,
  output logic         out_valid,
  output spq_pkg::out_t out_item
);
  import spq_pkg::*;

  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                out_valid_r;
  out_t                out_r, out_nxt;
  cell_ctl_t           ctl;

  logic   [DEPTH-1:0] valid;
  logic   [DEPTH-1:0] greater;
  entry_t             ents [DEPTH];

  wire accept = start && !busy;
  wire empty  = (count_r == '0);
  wire full   = (count_r == CNT_BITS'(DEPTH));

  assign busy = 1'b0;

  always_comb begin
    ctl.ins       = 1'b0;
    ctl.pop       = 1'b0;
    ctl.new_entry = '{key: in_item.key, tag: in_item.tag};
    count_nxt     = count_r;
    out_nxt       = '0;
    unique case (in_item.command) inside
      CMD_INSERT: begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          ctl.ins   = accept;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_PEEK, CMD_POP: begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.min_key = ents[0].key;
          out_nxt.min_tag = ents[0].tag;
          if (in_item.command == CMD_POP) begin
            ctl.pop   = accept;
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: ;
    endcase
    out_nxt.occupancy = OCC_BITS'(count_nxt);
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      entry_t pe, ne;
      logic   pg;
      assign valid[i] = (CNT_BITS'(i) < count_r);
      if (i == 0) begin : g_head
        assign pe = ctl.new_entry;
        assign pg = 1'b0;
      end else begin : g_body
        assign pe = ents[i-1];
        assign pg = greater[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign ne = ents[i];
      end else begin : g_mid
        assign ne = ents[i+1];
      end
      spq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .valid       (valid[i]),
        .prev_greater(pg),
        .prev_entry  (pe),
        .next_entry  (ne),
        .greater     (greater[i]),
        .entry       (ents[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(DEPTH)) else $error("entry count overflow");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid) else $error("missing result strobe");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_FULL) |->
      out_item.occupancy == OCC_BITS'(DEPTH)) else $error("full flagged below depth");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_EMPTY) |->
      (out_item.occupancy == '0 && out_item.min_key == '0 && out_item.min_tag == '0))
    else $error("empty flagged with entries held");

  a_occ_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.occupancy == OCC_BITS'(count_r))
    else $error("occupancy differs from count");

endmodule
